/* src/cbts_pkg.sv */
package cbts_pkg;

  localparam int unsigned PHASE1_MIN_DEF = 1;
  localparam int unsigned PHASE2_MAX_DEF = 8;
  localparam int unsigned SJW_LIMIT_DEF  = 4;

  localparam logic [9:0] PERMILLE_FULL = 10'd1000;

  // configuration register indexes
  localparam logic [2:0] CFG_CLOCK_HZ  = 3'd0;
  localparam logic [2:0] CFG_PRESC_MIN = 3'd1;
  localparam logic [2:0] CFG_PRESC_MAX = 3'd2;
  localparam logic [2:0] CFG_PRESC_STP = 3'd3;
  localparam logic [2:0] CFG_QUANTA_MIN = 3'd4;
  localparam logic [2:0] CFG_QUANTA_MAX = 3'd5;
  localparam logic [2:0] CFG_PHASE1_MAX = 3'd6;
  localparam logic [2:0] CFG_PHASE2_MIN = 3'd7;

  typedef struct packed {
    logic [31:0] bit_rate;
    logic [9:0]  sp_target;
  } cbts_req_t;

  typedef struct packed {
    logic        found_ok;
    logic [14:0] prescaler;
    logic [7:0]  phase1_quanta;
    logic [7:0]  phase2_quanta;
    logic [3:0]  jump_width;
    logic [7:0]  quanta_per_bit;
    logic [9:0]  sample_point_permille;
    logic [31:0] bitrate_echo;
  } cbts_res_t;

  typedef struct packed {
    logic [31:0] clk_freq;
    logic [14:0] prescaler_min;
    logic [14:0] prescaler_max;
    logic [14:0] prescaler_step;
    logic [7:0]  quanta_min;
    logic [7:0]  quanta_max;
    logic [7:0]  phase1_max;
    logic [7:0]  phase2_min;
  } cbts_cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic qinit;
    logic qstep;
    logic t1init;
    logic t1inc;
    logic spinit;
    logic spstep;
    logic update;
    logic next_div;
    logic emit;
  } cbts_cmd_t;

  typedef struct packed {
    logic no_go;
    logic div_over;
    logic div_zero;
    logic q_big;
    logic cnt_last;
    logic q_bad;
    logic walk_end;
    logic t2_bad;
    logic better;
    logic out_free;
  } cbts_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_RANGE,
    ST_QDIV,
    ST_QCHK,
    ST_WALK,
    ST_SDIV,
    ST_SCMP,
    ST_DONE
  } cbts_state_e;

endpackage

/* src/cbts_ctrl.sv */
module cbts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  cbts_pkg::cbts_stat_t stat_i,
  output cbts_pkg::cbts_cmd_t  cmd_o,
  output logic               busy_o
);

  cbts_pkg::cbts_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      cbts_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = cbts_pkg::ST_DIV;
        end
      end
      cbts_pkg::ST_DIV: begin
        if (stat_i.no_go || stat_i.div_over) begin
          state_d = cbts_pkg::ST_DONE;
        end else if (stat_i.div_zero) begin
          cmd_o.next_div = 1'b1;
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = cbts_pkg::ST_RANGE;
        end
      end
      cbts_pkg::ST_RANGE: begin
        if (stat_i.q_big) begin
          cmd_o.next_div = 1'b1;
          state_d        = cbts_pkg::ST_DIV;
        end else begin
          cmd_o.qinit = 1'b1;
          state_d     = cbts_pkg::ST_QDIV;
        end
      end
      cbts_pkg::ST_QDIV: begin
        cmd_o.qstep = 1'b1;
        if (stat_i.cnt_last) state_d = cbts_pkg::ST_QCHK;
      end
      cbts_pkg::ST_QCHK: begin
        if (stat_i.q_bad) begin
          cmd_o.next_div = 1'b1;
          state_d        = cbts_pkg::ST_DIV;
        end else begin
          cmd_o.t1init = 1'b1;
          state_d      = cbts_pkg::ST_WALK;
        end
      end
      cbts_pkg::ST_WALK: begin
        if (stat_i.walk_end) begin
          cmd_o.next_div = 1'b1;
          state_d        = cbts_pkg::ST_DIV;
        end else if (stat_i.t2_bad) begin
          cmd_o.t1inc = 1'b1;
        end else begin
          cmd_o.spinit = 1'b1;
          state_d      = cbts_pkg::ST_SDIV;
        end
      end
      cbts_pkg::ST_SDIV: begin
        cmd_o.spstep = 1'b1;
        if (stat_i.cnt_last) state_d = cbts_pkg::ST_SCMP;
      end
      cbts_pkg::ST_SCMP: begin
        cmd_o.update = stat_i.better;
        cmd_o.t1inc  = 1'b1;
        state_d      = cbts_pkg::ST_WALK;
      end
      cbts_pkg::ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = cbts_pkg::ST_IDLE;
        end
      end
      default: state_d = cbts_pkg::ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != cbts_pkg::ST_IDLE);

endmodule

/* src/cbts_dp.sv */
module cbts_dp #(
  parameter int unsigned PHASE1_MIN = cbts_pkg::PHASE1_MIN_DEF,
  parameter int unsigned PHASE2_MAX = cbts_pkg::PHASE2_MAX_DEF,
  parameter int unsigned SJW_LIMIT  = cbts_pkg::SJW_LIMIT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cbts_pkg::cbts_cfg_t cfg_i,
  input  cbts_pkg::cbts_req_t req_i,
  input  cbts_pkg::cbts_cmd_t cmd_i,
  output cbts_pkg::cbts_stat_t stat_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output cbts_pkg::cbts_res_t out_data_o
);

  logic [31:0] rate_q;
  logic [9:0]  target_q;
  logic [15:0] div_q;
  logic [47:0] denom_q;
  logic [31:0] rem_q;
  logic [7:0]  quo_q;
  logic [3:0]  cnt_q;
  logic [8:0]  t1_q;
  logic [17:0] spr_q;
  logic [9:0]  spq_q;
  logic        found_q;
  logic [9:0]  best_err_q;
  logic [14:0] b_div_q;
  logic [7:0]  b_t1_q, b_t2_q, b_tq_q;
  logic [9:0]  b_sp_q;
  logic        out_valid_q;
  cbts_pkg::cbts_res_t out_q;

  logic [55:0] qshift;
  logic        qfit;
  logic [17:0] sshift;
  logic        sfit;
  logic [7:0]  t2;
  logic [9:0]  err;
  logic [7:0]  tqm1, t1_skip, t1_start;
  logic [3:0]  sjw;

  assign qshift = {8'd0, denom_q} << cnt_q[2:0];
  assign qfit   = {24'd0, rem_q} >= qshift;
  assign sshift = {10'd0, quo_q} << cnt_q;
  assign sfit   = spr_q >= sshift;
  assign t2     = quo_q - 8'd1 - t1_q[7:0];
  assign err    = (spq_q > target_q) ? (spq_q - target_q) : (target_q - spq_q);
  assign tqm1   = quo_q - 8'd1;
  assign t1_skip = (tqm1 > 8'(PHASE2_MAX)) ? (tqm1 - 8'(PHASE2_MAX)) : 8'd0;
  assign t1_start = (t1_skip > 8'(PHASE1_MIN)) ? t1_skip : 8'(PHASE1_MIN);
  assign sjw    = (b_t2_q < 8'(SJW_LIMIT)) ? b_t2_q[3:0] : 4'(SJW_LIMIT);

  always_comb begin
    stat_o.no_go    = (rate_q == '0) || (cfg_i.clk_freq == '0) || (cfg_i.prescaler_step == '0);
    stat_o.div_over = div_q > {1'b0, cfg_i.prescaler_max};
    stat_o.div_zero = (div_q == '0);
    stat_o.q_big    = {24'd0, cfg_i.clk_freq} >= {denom_q, 8'd0};
    stat_o.cnt_last = (cnt_q == '0);
    stat_o.q_bad    = (rem_q != '0) || (quo_q < cfg_i.quanta_min) || (quo_q > cfg_i.quanta_max);
    stat_o.walk_end = (t1_q > {1'b0, cfg_i.phase1_max}) ||
                      ({1'b0, t1_q} + 10'd1 >= {2'd0, quo_q});
    stat_o.t2_bad   = (t2 < cfg_i.phase2_min) || (t2 > 8'(PHASE2_MAX));
    stat_o.better   = !found_q || (err < best_err_q);
    stat_o.out_free = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        found_q <= 1'b0;
      end else if (cmd_i.update) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rate_q     <= req_i.bit_rate;
      target_q   <= (req_i.sp_target > cbts_pkg::PERMILLE_FULL) ?
                    cbts_pkg::PERMILLE_FULL : req_i.sp_target;
      div_q      <= {1'b0, cfg_i.prescaler_min};
      best_err_q <= '0;
      b_div_q    <= '0;
      b_t1_q     <= '0;
      b_t2_q     <= '0;
      b_tq_q     <= '0;
      b_sp_q     <= '0;
    end
    if (cmd_i.next_div) div_q <= div_q + {1'b0, cfg_i.prescaler_step};
    if (cmd_i.mul) denom_q <= div_q * rate_q;
    if (cmd_i.qinit) begin
      rem_q <= cfg_i.clk_freq;
      quo_q <= '0;
      cnt_q <= 4'd7;
    end
    if (cmd_i.qstep) begin
      if (qfit) begin
        rem_q <= rem_q - qshift[31:0];
        quo_q[cnt_q[2:0]] <= 1'b1;
      end
      cnt_q <= cnt_q - 4'd1;
    end
    if (cmd_i.t1init) t1_q <= {1'b0, t1_start};
    if (cmd_i.t1inc) t1_q <= t1_q + 9'd1;
    if (cmd_i.spinit) begin
      spr_q <= ({10'd0, t1_q[7:0]} + 18'd1) * 18'd1000;
      spq_q <= '0;
      cnt_q <= 4'd9;
    end
    if (cmd_i.spstep) begin
      if (sfit) begin
        spr_q <= spr_q - sshift;
        spq_q[cnt_q] <= 1'b1;
      end
      cnt_q <= cnt_q - 4'd1;
    end
    if (cmd_i.update) begin
      best_err_q <= err;
      b_div_q    <= div_q[14:0];
      b_t1_q     <= t1_q[7:0];
      b_t2_q     <= t2;
      b_tq_q     <= quo_q;
      b_sp_q     <= spq_q;
    end
    if (cmd_i.emit) begin
      out_q.found_ok              <= found_q;
      out_q.prescaler             <= b_div_q;
      out_q.phase1_quanta         <= b_t1_q;
      out_q.phase2_quanta         <= b_t2_q;
      out_q.jump_width            <= sjw;
      out_q.quanta_per_bit        <= b_tq_q;
      out_q.sample_point_permille <= b_sp_q;
      out_q.bitrate_echo          <= found_q ? rate_q : 32'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* src/can_bit_timing_solver.sv */
// CAN bit timing solver.
// Input channel (in_valid_i / in_stall_o / in_data_i): one request holds a
// bit rate and a target sample point in permille. Output channel
// (out_valid_o / out_stall_i / out_data_o): one result per request, the best
// prescaler and segment split, or all zero with found_ok low.
// Configuration: write cfg_data_i to register cfg_idx_i while cfg_we_i is
// high; write only while no request is in flight.
// Per request the sequencer tries each prescaler in turn: it skips a zero
// prescaler, moves on when the quotient is at least 256, and otherwise runs
// the 8-step quotient division and, on an exact fit, walks the phase splits
// with a 10-step sample point division per legal split. It closes with the
// range check, the result load and the output register. One request at a
// time; the segment walk and the two shift-subtract dividers set the pace.
// Reset clears the sequencer and the output valid and loads the default
// register values. A result waiting under out_stall_i holds; a new request
// is still taken and solved, and its result waits until the output frees.
module can_bit_timing_solver #(
  parameter int unsigned PHASE1_MIN = cbts_pkg::PHASE1_MIN_DEF,
  parameter int unsigned PHASE2_MAX = cbts_pkg::PHASE2_MAX_DEF,
  parameter int unsigned SJW_LIMIT  = cbts_pkg::SJW_LIMIT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cbts_pkg::cbts_req_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cbts_pkg::cbts_res_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);

  cbts_pkg::cbts_cfg_t  cfg_q;
  cbts_pkg::cbts_cmd_t  cmd;
  cbts_pkg::cbts_stat_t stat;
  logic                 busy;

  // Configuration registers, masked to their widths on write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clk_freq       <= 32'd80000000;
      cfg_q.prescaler_min  <= 15'd2;
      cfg_q.prescaler_max  <= 15'd16384;
      cfg_q.prescaler_step <= 15'd2;
      cfg_q.quanta_min     <= 8'd3;
      cfg_q.quanta_max     <= 8'd25;
      cfg_q.phase1_max     <= 8'd16;
      cfg_q.phase2_min     <= 8'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cbts_pkg::CFG_CLOCK_HZ:   cfg_q.clk_freq       <= cfg_data_i;
        cbts_pkg::CFG_PRESC_MIN:  cfg_q.prescaler_min  <= cfg_data_i[14:0];
        cbts_pkg::CFG_PRESC_MAX:  cfg_q.prescaler_max  <= cfg_data_i[14:0];
        cbts_pkg::CFG_PRESC_STP:  cfg_q.prescaler_step <= cfg_data_i[14:0];
        cbts_pkg::CFG_QUANTA_MIN: cfg_q.quanta_min     <= cfg_data_i[7:0];
        cbts_pkg::CFG_QUANTA_MAX: cfg_q.quanta_max     <= cfg_data_i[7:0];
        cbts_pkg::CFG_PHASE1_MAX: cfg_q.phase1_max     <= cfg_data_i[7:0];
        cbts_pkg::CFG_PHASE2_MIN: cfg_q.phase2_min     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer: walks prescalers and phase splits, issues datapath commands.
  cbts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  // Datapath: multiplier, two shift-subtract dividers, best-candidate store
  // and the output register.
  cbts_dp #(
    .PHASE1_MIN (PHASE1_MIN),
    .PHASE2_MAX (PHASE2_MAX),
    .SJW_LIMIT  (SJW_LIMIT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_i       (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // Take a request only while the sequencer is idle.
  assign in_stall_o = busy;

endmodule

/* src/cbts_checker.sv */
module cbts_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input cbts_pkg::cbts_res_t out_data_o
);

  // an accepted request makes the block busy
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("not busy after request");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a new result only comes from a running solve
  a_out_from_solve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without solve");

  // not found reads as all zero
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found_ok |-> out_data_o == '0)
    else $error("not found result not zero");

  // segments add up to the bit
  a_segments_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found_ok |->
      ({1'b0, out_data_o.phase1_quanta} + {1'b0, out_data_o.phase2_quanta} + 9'd1)
        == {1'b0, out_data_o.quanta_per_bit})
    else $error("segments do not sum to quanta");

endmodule

bind can_bit_timing_solver cbts_checker u_cbts_checker (.*);
